// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds on every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Types and constants of the min/max contrast stretch block.
// ----------------------------------------------------------------------------
package csm_pkg;

	localparam int PIXEL_BITS    = 8;
	localparam int WORD_BITS     = 64;
	localparam int CFG_W         = 13;
	localparam int GAIN_W        = 16;
	localparam int LANES_DEF     = 8;
	localparam int MAX_WORDS_DEF = 4096;

	localparam logic [GAIN_W-1:0]     FULL_SCALE      = 16'(255 * 256);
	localparam logic [PIXEL_BITS-1:0] PIX_MAX         = 8'd255;
	localparam logic [PIXEL_BITS-1:0] PIX_MIN         = 8'd0;
	localparam logic [CFG_W-1:0]      IMAGE_WORDS_RST = 13'd1;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EMIT = 1'b1;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SETUP,
		ST_DIV,
		ST_EMIT,
		ST_DRAIN
	} csm_state_t;

	typedef struct packed {
		logic                 opcode;
		logic [WORD_BITS-1:0] pixel_word;
	} in_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] scaled_word;
		logic                 last;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic emit;
		logic div_start;
	} csm_cmd_t;

	typedef struct packed {
		logic final_word;
		logic div_done;
		logic s1_free;
		logic pipe_empty;
	} csm_sts_t;

endpackage

// ===== hdl/contrast_stretch_minmax.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch_minmax
// Min/max contrast stretch over one image held in an internal word store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): opcode load writes one word of
// eight 8-bit pixels, opcode emit requests the next rescaled word. Wrong-phase
// items are taken and dropped. Output channel (out_valid/out_ready/out_data)
// carries one scaled word per emit, last set on the final word of the image.
// cfg_we/cfg_wdata sets the image length; write it only while idle.
// Loads transfer one per cycle. After the final load the gain is computed by
// a restoring divider, one quotient bit per cycle, while in_ready stays low.
// Emits then transfer one per cycle while out_ready stays high; out_valid
// rises after the store read, multiply and clamp into the output register.
// After the final emit in_ready stays low until the scaling stages are empty,
// longer while out_ready is low, and loading then resumes. When out_ready is
// low the pipeline holds; in_ready drops once all stages are full, so nothing
// is lost. Reset: loading phase, word index 0, min 255, max 0, length 1.
// The image store is not cleared; the user must write each word before it is
// read back, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module contrast_stretch_minmax #(
	parameter int LANES     = csm_pkg::LANES_DEF,
	parameter int MAX_WORDS = csm_pkg::MAX_WORDS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [csm_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  csm_pkg::in_item_t         in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output csm_pkg::out_item_t        out_data
);

	csm_pkg::csm_cmd_t cmd;
	csm_pkg::csm_sts_t sts;

	csm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (in_data.opcode),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	csm_dp #(
		.LANES     (LANES),
		.MAX_WORDS (MAX_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== hdl/csm_div.sv =====
// ----------------------------------------------------------------------------
// csm_div
// Restoring divider: full-scale constant over an 8-bit range, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module csm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [csm_pkg::PIXEL_BITS-1:0]  divisor,
	output logic                            done,
	output logic [csm_pkg::GAIN_W-1:0]      quotient
);

	localparam int PB    = csm_pkg::PIXEL_BITS;
	localparam int GW    = csm_pkg::GAIN_W;
	localparam int CNT_W = $clog2(GW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PB-1:0]    rem_q;
	logic [PB-1:0]    dvs_q;
	logic [GW-1:0]    quo_q;

	logic [PB:0]      trial;
	logic             ge;
	logic [PB-1:0]    rem_n;

	always_comb begin
		trial = {rem_q, quo_q[GW-1]};
		ge    = trial >= {1'b0, dvs_q};
		rem_n = ge ? PB'(trial - {1'b0, dvs_q}) : trial[PB-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(GW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= csm_pkg::FULL_SCALE;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[GW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== hdl/csm_dp.sv =====
// ----------------------------------------------------------------------------
// csm_dp
// Datapath: image store, word index, running min/max, gain divider and the
// three-stage scaling pipeline with its output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csm_dp #(
	parameter int LANES     = csm_pkg::LANES_DEF,
	parameter int MAX_WORDS = csm_pkg::MAX_WORDS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [csm_pkg::CFG_W-1:0]    cfg_wdata,
	input  csm_pkg::in_item_t            in_data,
	input  csm_pkg::csm_cmd_t            cmd,
	output csm_pkg::csm_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output csm_pkg::out_item_t           out_data
);

	localparam int PB     = csm_pkg::PIXEL_BITS;
	localparam int WB     = csm_pkg::WORD_BITS;
	localparam int GW     = csm_pkg::GAIN_W;
	localparam int PROD_W = GW + PB;
	localparam int IDX_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int CMP_W  = (csm_pkg::CFG_W > IDX_W + 1) ? csm_pkg::CFG_W : IDX_W + 1;

	logic [csm_pkg::CFG_W-1:0] image_words_q;
	logic [IDX_W-1:0]          idx_q;
	logic [PB-1:0]             run_min_q;
	logic [PB-1:0]             run_max_q;
	logic [GW-1:0]             gain_q;
	logic [PB-1:0]             lo_q;
	logic                      pass_q;

	logic [WB-1:0] mem [MAX_WORDS];

	logic [CMP_W-1:0] cfg_ext;
	logic [IDX_W-1:0] last_idx;
	logic             final_w;
	logic [PB-1:0]    fold_min;
	logic [PB-1:0]    fold_max;

	logic             div_done;
	logic [GW-1:0]    quotient;

	logic [WB-1:0]     rd_word_s1;
	logic              last_s1;
	logic              s1v_q;
	logic [PROD_W-1:0] prod_s2 [LANES];
	logic [PB-1:0]     raw_s2 [LANES];
	logic              below_s2 [LANES];
	logic              pass_s2;
	logic              last_s2;
	logic              s2v_q;
	logic              out_v_q;
	csm_pkg::out_item_t out_q;

	logic              s1_adv;
	logic              s2_adv;
	logic [WB-1:0]     scaled;

	// effective image length, clamped to 1..MAX_WORDS
	always_comb begin
		cfg_ext = CMP_W'(image_words_q);
		if (cfg_ext == '0) begin
			last_idx = '0;
		end else if (cfg_ext >= CMP_W'(MAX_WORDS)) begin
			last_idx = IDX_W'(MAX_WORDS - 1);
		end else begin
			last_idx = IDX_W'(cfg_ext - CMP_W'(1));
		end
		final_w = idx_q >= last_idx;
	end

	always_comb begin
		logic [PB-1:0] p;
		fold_min = run_min_q;
		fold_max = run_max_q;
		for (int j = 0; j < LANES; j++) begin
			p = in_data.pixel_word[j*PB +: PB];
			if (p < fold_min) begin
				fold_min = p;
			end
			if (p > fold_max) begin
				fold_max = p;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_words_q <= csm_pkg::IMAGE_WORDS_RST;
			idx_q         <= '0;
			run_min_q     <= csm_pkg::PIX_MAX;
			run_max_q     <= csm_pkg::PIX_MIN;
		end else begin
			if (cfg_we) begin
				image_words_q <= cfg_wdata;
			end
			if (cmd.load) begin
				run_min_q <= fold_min;
				run_max_q <= fold_max;
				idx_q     <= final_w ? '0 : idx_q + 1'b1;
			end else if (cmd.emit) begin
				idx_q <= final_w ? '0 : idx_q + 1'b1;
				if (final_w) begin
					run_min_q <= csm_pkg::PIX_MAX;
					run_max_q <= csm_pkg::PIX_MIN;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[idx_q] <= in_data.pixel_word;
		end
		if (cmd.emit) begin
			rd_word_s1 <= mem[idx_q];
			last_s1    <= final_w;
		end
	end

	csm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.divisor  (PB'(run_max_q - run_min_q)),
		.done     (div_done),
		.quotient (quotient)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			gain_q <= quotient;
			lo_q   <= run_min_q;
			pass_q <= run_max_q <= run_min_q;
		end
	end

	assign s2_adv = s2v_q && (!out_v_q || out_ready);
	assign s1_adv = s1v_q && (!s2v_q || s2_adv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1v_q   <= 1'b0;
			s2v_q   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				s1v_q <= 1'b1;
			end else if (s1_adv) begin
				s1v_q <= 1'b0;
			end
			if (s1_adv) begin
				s2v_q <= 1'b1;
			end else if (s2_adv) begin
				s2v_q <= 1'b0;
			end
			if (s2_adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [PB-1:0] p;
		if (s1_adv) begin
			for (int j = 0; j < LANES; j++) begin
				p           = rd_word_s1[j*PB +: PB];
				raw_s2[j]   <= p;
				below_s2[j] <= p < lo_q;
				prod_s2[j]  <= PROD_W'(gain_q) * PROD_W'(PB'(p - lo_q));
			end
			pass_s2 <= pass_q;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		logic [GW-1:0] v;
		scaled = '0;
		for (int j = 0; j < LANES; j++) begin
			v = prod_s2[j][PROD_W-1:PB];
			if (pass_s2) begin
				scaled[j*PB +: PB] = raw_s2[j];
			end else if (below_s2[j]) begin
				scaled[j*PB +: PB] = csm_pkg::PIX_MIN;
			end else if (|v[GW-1:PB]) begin
				scaled[j*PB +: PB] = csm_pkg::PIX_MAX;
			end else begin
				scaled[j*PB +: PB] = v[PB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			out_q.scaled_word <= scaled;
			out_q.last        <= last_s2;
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	assign sts.final_word = final_w;
	assign sts.div_done   = div_done;
	assign sts.s1_free    = !s1v_q || s1_adv;
	assign sts.pipe_empty = !s1v_q && !s2v_q;

	`ASSERT_IMPLIES(a_emit_slot_free, cmd.emit, !s1v_q || s1_adv, "emit read into busy stage")
	`ASSERT_NEXT(a_s2_hold, s2v_q && out_v_q && !out_ready, s2v_q, "stalled product lost")
	`ASSERT_IMPLIES(a_gain_range, div_done && (run_max_q > run_min_q), quotient >= GW'(256), "gain below unity")

endmodule

// ===== hdl/csm_ctrl.sv =====
// ----------------------------------------------------------------------------
// csm_ctrl
// Phase controller: load, gain setup, emit and pipeline drain.
// ----------------------------------------------------------------------------
module csm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 opcode,
	output logic                 in_ready,
	input  csm_pkg::csm_sts_t    sts,
	output csm_pkg::csm_cmd_t    cmd
);

	csm_pkg::csm_state_t state_q;
	csm_pkg::csm_state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= csm_pkg::ST_LOAD;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			csm_pkg::ST_LOAD: begin
				if (in_valid && opcode == csm_pkg::OP_LOAD && sts.final_word) begin
					state_n = csm_pkg::ST_SETUP;
				end
			end
			csm_pkg::ST_SETUP: begin
				state_n = csm_pkg::ST_DIV;
			end
			csm_pkg::ST_DIV: begin
				if (sts.div_done) begin
					state_n = csm_pkg::ST_EMIT;
				end
			end
			csm_pkg::ST_EMIT: begin
				if (in_valid && sts.s1_free && opcode == csm_pkg::OP_EMIT
						&& sts.final_word) begin
					state_n = csm_pkg::ST_DRAIN;
				end
			end
			csm_pkg::ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_n = csm_pkg::ST_LOAD;
				end
			end
			default: begin
				state_n = csm_pkg::ST_LOAD;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load      = 1'b0;
		cmd.emit      = 1'b0;
		cmd.div_start = 1'b0;
		unique case (state_q)
			csm_pkg::ST_LOAD: begin
				in_ready = 1'b1;
				cmd.load = in_valid && opcode == csm_pkg::OP_LOAD;
			end
			csm_pkg::ST_SETUP: begin
				cmd.div_start = 1'b1;
			end
			csm_pkg::ST_EMIT: begin
				in_ready = sts.s1_free;
				cmd.emit = in_valid && sts.s1_free && opcode == csm_pkg::OP_EMIT;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== test/contrast_stretch_minmax_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// contrast_stretch_minmax_test
// Self-checking bench for the min/max contrast stretch block. A local
// predictor mirrors the image store, the running min/max and the phase logic.
// Every emit taken in the emit phase queues the expected scaled word; each output
// transfer is compared against the oldest entry. Directed tests cover pixel
// extremes, flat images, wrong-phase items and image length changes between
// phases. The random tests follow with idle bursts on both channels, a long
// output hold-off and a final burst with no idling.
// ----------------------------------------------------------------------------
module contrast_stretch_minmax_test;
	import csm_pkg::*;

	localparam int CLK_PERIOD   = 20;
	localparam int STORE_DEPTH  = MAX_WORDS_DEF;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES  = 300;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic             in_valid;
	logic             in_ready;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_item_t        out_data;

	// predictor state
	logic [WORD_BITS-1:0]  m_store [STORE_DEPTH];
	bit                    m_written [STORE_DEPTH];
	logic [11:0]           m_index;
	bit                    m_emitting;
	logic [PIXEL_BITS-1:0] m_lo;
	logic [PIXEL_BITS-1:0] m_hi;
	logic [CFG_W-1:0]      m_len;

	out_item_t scaled_q[$];

	bit gaps_on;
	bit stalls_on;
	bit hold_req;
	int img_base;
	int img_spread;
	int n_fail;
	int n_checked;
	int n_images;
	int n_sent;

	contrast_stretch_minmax u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("%0t: timeout, transfers still pending", $time);
		$display("Regression FAIL");
		$finish;
	end

	function automatic int eff_len(logic [CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > STORE_DEPTH)
			return STORE_DEPTH;
		return int'(v);
	endfunction

	function automatic bit span_written(int n);
		for (int i = 0; i < n; i++)
			if (!m_written[i])
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [PIXEL_BITS-1:0] stretch_pixel(logic [PIXEL_BITS-1:0] p,
			logic [PIXEL_BITS-1:0] lo, logic [PIXEL_BITS-1:0] hi);
		logic [15:0] gain;
		logic [23:0] v;
		if (hi <= lo)
			return p;
		if (p < lo)
			return PIX_MIN;
		gain = FULL_SCALE / (16'(hi) - 16'(lo));
		v = (24'(gain) * 24'(p - lo)) >> 8;
		return (v > 24'd255) ? PIX_MAX : v[7:0];
	endfunction

	// returns 1 when the item produces a scaled word
	function automatic bit stretch_predict(in_item_t it, output out_item_t res);
		int n;
		int idx;
		int j;
		bit fin;
		logic [PIXEL_BITS-1:0] px;
		n = eff_len(m_len);
		idx = int'(m_index);
		fin = idx >= n - 1;
		res = '0;
		if (it.opcode == OP_LOAD) begin
			if (m_emitting)
				return 1'b0;
			m_store[idx] = it.pixel_word;
			m_written[idx] = 1'b1;
			for (j = 0; j < LANES_DEF; j++) begin
				px = it.pixel_word[PIXEL_BITS*j +: PIXEL_BITS];
				if (px < m_lo)
					m_lo = px;
				if (px > m_hi)
					m_hi = px;
			end
			if (fin) begin
				m_emitting = 1'b1;
				m_index = '0;
			end else begin
				m_index = m_index + 12'd1;
			end
			return 1'b0;
		end
		if (!m_emitting)
			return 1'b0;
		for (j = 0; j < LANES_DEF; j++)
			res.scaled_word[PIXEL_BITS*j +: PIXEL_BITS] =
				stretch_pixel(m_store[idx][PIXEL_BITS*j +: PIXEL_BITS], m_lo, m_hi);
		res.last = fin;
		if (fin) begin
			m_emitting = 1'b0;
			m_index = '0;
			m_lo = PIX_MAX;
			m_hi = PIX_MIN;
		end else begin
			m_index = m_index + 12'd1;
		end
		return 1'b1;
	endfunction

	// 0 = any content, 1 = narrow band around img_base, 2 = flat, 3 = only 0 or 255
	function automatic logic [WORD_BITS-1:0] rand_word(int mode);
		logic [WORD_BITS-1:0] w;
		int v;
		w = {$urandom, $urandom};
		for (int j = 0; j < LANES_DEF; j++) begin
			case (mode)
				1: begin
					v = img_base + $urandom_range(0, img_spread);
					w[PIXEL_BITS*j +: PIXEL_BITS] = (v > 255) ? PIX_MAX : 8'(v);
				end
				2: begin
					w[PIXEL_BITS*j +: PIXEL_BITS] = 8'(img_base);
				end
				3: begin
					w[PIXEL_BITS*j +: PIXEL_BITS] = $urandom_range(0, 1) ? PIX_MAX : PIX_MIN;
				end
				default: begin
				end
			endcase
		end
		return w;
	endfunction

	task automatic send_item(logic op, logic [WORD_BITS-1:0] w);
		in_item_t it;
		out_item_t res;
		bit useful;
		it.opcode = op;
		it.pixel_word = w;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!(in_valid && in_ready));
		useful = (op == OP_LOAD) ? !m_emitting : m_emitting;
		if (stretch_predict(it, res))
			scaled_q.push_back(res);
		if (useful)
			n_sent++;
	endtask

	// only while idle: all results in, divider and drain done
	task automatic set_length(logic [CFG_W-1:0] v);
		in_valid <= 1'b0;
		while (scaled_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wdata <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		m_len = v;
	endtask

	task automatic maybe_resize(int max_len);
		logic [CFG_W-1:0] v;
		v = CFG_W'($urandom_range(0, max_len));
		if (!m_emitting || span_written(eff_len(v)))
			set_length(v);
	endtask

	task automatic run_loads(int mode, bit noise);
		while (!m_emitting) begin
			if (noise && $urandom_range(0, 9) == 0)
				send_item(OP_EMIT, rand_word(0));
			send_item(OP_LOAD, rand_word(mode));
		end
	endtask

	task automatic run_emits(bit noise, bit resize);
		while (m_emitting) begin
			if (noise && $urandom_range(0, 9) == 0)
				send_item(OP_LOAD, rand_word(0));
			if (resize && $urandom_range(0, 15) == 0)
				maybe_resize(16);
			if (m_emitting)
				send_item(OP_EMIT, rand_word(0));
		end
	endtask

	task automatic pick_content(output int mode);
		mode = $urandom_range(0, 3);
		img_base = $urandom_range(0, 255);
		img_spread = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 80);
	endtask

	// --------------------------------------------------------------------
	// tests
	// --------------------------------------------------------------------
	task automatic test_extremes();
		send_item(OP_LOAD, '1);
		send_item(OP_EMIT, '0);
		send_item(OP_EMIT, '1);
		send_item(OP_LOAD, '0);
		send_item(OP_LOAD, '1);
		send_item(OP_EMIT, '1);
		send_item(OP_LOAD, 64'hFF00_FF00_FF00_FF00);
		send_item(OP_EMIT, 64'h5555_AAAA_5555_AAAA);
	endtask

	task automatic test_length_change();
		set_length(13'd3);
		send_item(OP_LOAD, 64'h00FF_1020_3040_5060);
		send_item(OP_LOAD, 64'h7080_90A0_B0C0_D0E0);
		send_item(OP_LOAD, 64'hF0F8_FC0F_0703_0100);
		run_emits(1'b0, 1'b0);
		// narrow image, then stretch emit over an older wide word
		set_length(13'd2);
		send_item(OP_LOAD, 64'h8081_8283_8485_8687);
		send_item(OP_LOAD, 64'h8887_8685_8483_8281);
		set_length(13'd3);
		run_emits(1'b0, 1'b0);
		// shorten mid-load: next load ends the phase
		set_length(13'd4);
		send_item(OP_LOAD, 64'h0123_4567_89AB_CDEF);
		send_item(OP_LOAD, 64'hFEDC_BA98_7654_3210);
		set_length(13'd1);
		send_item(OP_LOAD, 64'h1111_2222_3333_4444);
		run_emits(1'b0, 1'b0);
		// zero length acts as one word
		set_length(13'd0);
		send_item(OP_LOAD, 64'h3C3C_3C3C_3C3C_3C3D);
		send_item(OP_EMIT, '0);
	endtask

	// lengths at and above the store depth, cut short mid-load
	task automatic test_length_clamp();
		set_length(13'h1FFF);
		repeat (6)
			send_item(OP_LOAD, rand_word(0));
		set_length(13'd3);
		send_item(OP_LOAD, rand_word(0));
		run_emits(1'b0, 1'b0);
		set_length(13'd4096);
		repeat (3)
			send_item(OP_LOAD, rand_word(3));
		set_length(13'd1);
		send_item(OP_LOAD, rand_word(3));
		run_emits(1'b0, 1'b0);
	endtask

	task automatic test_output_hold();
		set_length(13'd48);
		run_loads(0, 1'b0);
		hold_req = 1'b1;
		run_emits(1'b0, 1'b0);
	endtask

	task automatic test_random_images();
		int target;
		int mode;
		target = n_sent + 600;
		while (n_sent < target) begin
			gaps_on = $urandom_range(0, 3) != 0;
			stalls_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 9) == 0)
				set_length(CFG_W'($urandom_range(1, 64)));
			else
				set_length(CFG_W'($urandom_range(1, 12)));
			pick_content(mode);
			if ($urandom_range(0, 7) == 0) begin
				send_item(OP_LOAD, rand_word(mode));
				maybe_resize(12);
			end
			run_loads(mode, 1'b1);
			if ($urandom_range(0, 5) == 0)
				maybe_resize(16);
			run_emits(1'b1, 1'b1);
		end
	endtask

	task automatic test_streaming();
		int target;
		int mode;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		target = n_sent + 150;
		while (n_sent < target) begin
			set_length(CFG_W'($urandom_range(1, 20)));
			pick_content(mode);
			run_loads(mode, 1'b0);
			run_emits(1'b0, 1'b0);
		end
	endtask

	// --------------------------------------------------------------------
	// output side: random stalls, long hold-off on request
	// --------------------------------------------------------------------
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		out_item_t exp_item;
		if (arst_n && out_valid && out_ready) begin
			if (scaled_q.size() == 0) begin
				$display("%0t: unexpected transfer, actual word %h last %b",
					$time, out_data.scaled_word, out_data.last);
				n_fail++;
			end else begin
				exp_item = scaled_q.pop_front();
				n_checked++;
				if (exp_item.last)
					n_images++;
				if (out_data.scaled_word !== exp_item.scaled_word) begin
					$display("%0t: scaled_word mismatch, expected %h actual %h",
						$time, exp_item.scaled_word, out_data.scaled_word);
					n_fail++;
				end
				if (out_data.last !== exp_item.last) begin
					$display("%0t: last mismatch, expected %b actual %b",
						$time, exp_item.last, out_data.last);
					n_fail++;
				end
			end
		end
	end

	initial begin
		int k;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		hold_req = 1'b0;
		m_index = '0;
		m_emitting = 1'b0;
		m_lo = PIX_MAX;
		m_hi = PIX_MIN;
		m_len = IMAGE_WORDS_RST;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_extremes();
		test_length_change();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_length_clamp();
		test_output_hold();
		test_random_images();
		test_streaming();

		in_valid <= 1'b0;
		for (k = 0; k < 20000 && scaled_q.size() != 0; k++)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (scaled_q.size() != 0) begin
			$display("%0t: %0d expected words never arrived", $time, scaled_q.size());
			n_fail++;
		end

		$display("Checked %0d scaled words over %0d images from %0d input transfers,",
			n_checked, n_images, n_sent);
		$display("including length clamping, length changes and a long output hold.");
		if (n_fail == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/csm_pkg.sv
hdl/csm_div.sv
hdl/csm_dp.sv
hdl/csm_ctrl.sv
hdl/contrast_stretch_minmax.sv
test/contrast_stretch_minmax_test.sv
